// ===== rtl/dtq_pkg.sv =====
// dtq_pkg: shared types and sizes for the delta-list timer queue.
// Used by dtq_free_pick and delta_timer_queue; depends on nothing.
package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_BITS    = 8;
    localparam int DELAY_BITS  = 40;
    localparam int TIME_BITS   = 48;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_EXPIRE   = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [TIME_BITS-1:0]  now_us;
        logic [DELAY_BITS-1:0] delay_us;
        logic [TAG_BITS-1:0]   task_tag;
    } req_item_t;

    typedef struct packed {
        logic                  fired;
        logic [TAG_BITS-1:0]   fired_tag;
        logic                  accepted;
        logic [DELAY_BITS-1:0] head_delay_us;
        logic                  queue_empty;
        logic                  last;
    } rsp_item_t;

endpackage

// ===== rtl/delta_timer_queue.sv =====
// delta_timer_queue: top level of the delta-list timer queue.
// Depends on dtq_pkg and dtq_free_pick.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one item: op, the current
//   time now_us, and for a schedule the delay and the task tag. req_stall is
//   high whenever the block is busy with an item; one item is worked at a time.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns results. A schedule gives
//   one result (accepted 0 when the queue is full). An expire gives one result
//   per fired task, or a single result with fired 0 when nothing is due. The
//   final result of each item carries last.
//   Storage: the list lives in three 16-entry memories with a registered read,
//   so every visited entry passes a wait state before it is used.
//   Synchronizing walks the head entries the elapsed time covers, a schedule
//   walks to its insert point, and an expire reads the head once per fired task.
//   Results sit in an output register; a new item is taken while a result waits
//   there. With that register full and stalled, it holds before its next result.
//   Reset empties the queue and zeroes the last-sync time; the memories are not
//   cleared, since only entries on the live list are ever read.
module delta_timer_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dtq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dtq_pkg::rsp_item_t rsp
);
    import dtq_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SYNC   = 4'd1;
    localparam logic [3:0] ST_S_WAIT = 4'd2;
    localparam logic [3:0] ST_S_EV   = 4'd3;
    localparam logic [3:0] ST_INS    = 4'd4;
    localparam logic [3:0] ST_I_WAIT = 4'd5;
    localparam logic [3:0] ST_I_EV   = 4'd6;
    localparam logic [3:0] ST_I_WR   = 4'd7;
    localparam logic [3:0] ST_I_LINK = 4'd8;
    localparam logic [3:0] ST_RES    = 4'd9;
    localparam logic [3:0] ST_R_WAIT = 4'd10;
    localparam logic [3:0] ST_R_EV   = 4'd11;
    localparam logic [3:0] ST_X_WAIT = 4'd12;
    localparam logic [3:0] ST_X_CHK  = 4'd13;

    // list storage
    logic [DELAY_BITS-1:0] delta_mem [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   tag_mem   [QUEUE_DEPTH];
    logic [SLOT_BITS-1:0]  link_mem  [QUEUE_DEPTH];

    logic [DELAY_BITS-1:0] rd_delta;
    logic [TAG_BITS-1:0]   rd_tag;
    logic [SLOT_BITS-1:0]  rd_link;

    logic                  delta_we, tag_we, link_we;
    logic [SLOT_BITS-1:0]  delta_wa, tag_wa, link_wa;
    logic [DELAY_BITS-1:0] delta_wd;
    logic [TAG_BITS-1:0]   tag_wd;
    logic [SLOT_BITS-1:0]  link_wd;

    // control state
    logic [3:0]             state_reg, state_next;
    logic [SLOT_BITS-1:0]   head_reg, head_next;
    logic [QUEUE_DEPTH-1:0] free_reg, free_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [TIME_BITS-1:0]   sync_reg, sync_next;
    logic [SLOT_BITS-1:0]   cur_reg, cur_next;
    logic [SLOT_BITS-1:0]   prev_reg, prev_next;
    logic                   has_prev_reg, has_prev_next;
    logic [CNT_BITS-1:0]    left_reg, left_next;
    logic [TIME_BITS-1:0]   elapsed_reg, elapsed_next;
    logic                   first_reg, first_next;
    logic                   pend_reg, pend_next;
    logic [TAG_BITS-1:0]    pend_tag_reg, pend_tag_next;
    logic                   acc_reg, acc_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_item_t              rsp_reg, rsp_next;
    req_item_t              item_reg, item_next;

    logic [SLOT_BITS-1:0]  free_slot;
    logic                  slot_open;
    logic                  can_pop;
    logic [DELAY_BITS-1:0] head_view;
    logic [TIME_BITS-1:0]  rd_delta_w;

    dtq_free_pick u_pick (
        .free_map (free_reg),
        .slot     (free_slot)
    );

    assign slot_open  = !rsp_valid_reg || !rsp_stall;
    assign head_view  = (count_reg != '0) ? rd_delta : '1;
    assign can_pop    = (count_reg != '0) && (rd_delta == '0);
    assign rd_delta_w = TIME_BITS'(rd_delta);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        rd_delta <= delta_mem[cur_reg];
        rd_tag   <= tag_mem[cur_reg];
        rd_link  <= link_mem[cur_reg];
        if (delta_we)
        begin
            delta_mem[delta_wa] <= delta_wd;
        end
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        sync_next      = sync_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        has_prev_next  = has_prev_reg;
        left_next      = left_reg;
        elapsed_next   = elapsed_reg;
        first_next     = first_reg;
        pend_next      = pend_reg;
        pend_tag_next  = pend_tag_reg;
        acc_next       = acc_reg;
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        delta_we = 1'b0;
        delta_wa = cur_reg;
        delta_wd = '0;
        tag_we   = 1'b0;
        tag_wa   = free_slot;
        tag_wd   = item_reg.task_tag;
        link_we  = 1'b0;
        link_wa  = free_slot;
        link_wd  = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    pend_next = 1'b0;
                    if (req.op == OP_EXPIRE)
                    begin
                        // look at the head before deciding to synchronize
                        first_next = 1'b1;
                        cur_next   = head_reg;
                        state_next = ST_X_WAIT;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        state_next = ST_SYNC;
                    end
                end
            end
            ST_SYNC:
            begin
                sync_next = item_reg.now_us;
                if (item_reg.now_us < sync_reg || count_reg == '0)
                begin
                    // clock went backwards or nothing queued: re-base only
                    cur_next   = head_reg;
                    state_next = (item_reg.op == OP_EXPIRE) ? ST_X_WAIT : ST_INS;
                end
                else
                begin
                    elapsed_next = item_reg.now_us - sync_reg;
                    left_next    = count_reg;
                    cur_next     = head_reg;
                    state_next   = ST_S_WAIT;
                end
            end
            ST_S_WAIT:
            begin
                state_next = ST_S_EV;
            end
            ST_S_EV:
            begin
                delta_we = 1'b1;
                delta_wa = cur_reg;
                if (elapsed_reg >= rd_delta_w)
                begin
                    // entry fully covered: drop it to zero and advance
                    delta_wd     = '0;
                    elapsed_next = elapsed_reg - rd_delta_w;
                    left_next    = left_reg - CNT_BITS'(1);
                    if (left_reg == CNT_BITS'(1))
                    begin
                        cur_next   = head_reg;
                        state_next = (item_reg.op == OP_EXPIRE) ? ST_X_WAIT : ST_INS;
                    end
                    else
                    begin
                        cur_next   = rd_link;
                        state_next = ST_S_WAIT;
                    end
                end
                else
                begin
                    delta_wd   = rd_delta - elapsed_reg[DELAY_BITS-1:0];
                    cur_next   = head_reg;
                    state_next = (item_reg.op == OP_EXPIRE) ? ST_X_WAIT : ST_INS;
                end
            end
            ST_INS:
            begin
                if (count_reg >= CNT_BITS'(QUEUE_DEPTH))
                begin
                    acc_next   = 1'b0;
                    state_next = ST_RES;
                end
                else
                begin
                    acc_next      = 1'b1;
                    cur_next      = head_reg;
                    left_next     = '0;
                    has_prev_next = 1'b0;
                    elapsed_next  = TIME_BITS'(item_reg.delay_us);
                    state_next    = ST_I_WAIT;
                end
            end
            ST_I_WAIT:
            begin
                state_next = ST_I_EV;
            end
            ST_I_EV:
            begin
                if (left_reg < count_reg &&
                    elapsed_reg[DELAY_BITS-1:0] >= rd_delta)
                begin
                    // step past entries due no later than the new one
                    elapsed_next  = TIME_BITS'(elapsed_reg[DELAY_BITS-1:0] - rd_delta);
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    cur_next      = rd_link;
                    left_next     = left_reg + CNT_BITS'(1);
                    state_next    = ST_I_WAIT;
                end
                else
                begin
                    if (left_reg < count_reg)
                    begin
                        delta_we = 1'b1;
                        delta_wa = cur_reg;
                        delta_wd = rd_delta - elapsed_reg[DELAY_BITS-1:0];
                    end
                    else
                    begin
                        cur_next = '0;
                    end
                    state_next = ST_I_WR;
                end
            end
            ST_I_WR:
            begin
                delta_we = 1'b1;
                delta_wa = free_slot;
                delta_wd = elapsed_reg[DELAY_BITS-1:0];
                tag_we   = 1'b1;
                link_we  = 1'b1;
                link_wa  = free_slot;
                link_wd  = cur_reg;
                free_next  = free_reg & ~(QUEUE_DEPTH'(1) << free_slot);
                count_next = count_reg + CNT_BITS'(1);
                cur_next   = free_slot;
                if (has_prev_reg)
                begin
                    state_next = ST_I_LINK;
                end
                else
                begin
                    head_next  = free_slot;
                    state_next = ST_RES;
                end
            end
            ST_I_LINK:
            begin
                // cur holds the new slot here
                link_we    = 1'b1;
                link_wa    = prev_reg;
                link_wd    = cur_reg;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                cur_next   = head_reg;
                state_next = ST_R_WAIT;
            end
            ST_R_WAIT:
            begin
                state_next = ST_R_EV;
            end
            ST_R_EV:
            begin
                if (slot_open)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.fired        = 1'b0;
                    rsp_next.fired_tag    = '0;
                    rsp_next.accepted     = acc_reg;
                    rsp_next.head_delay_us = head_view;
                    rsp_next.queue_empty  = (count_reg == '0);
                    rsp_next.last         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            ST_X_WAIT:
            begin
                state_next = ST_X_CHK;
            end
            ST_X_CHK:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    if (count_reg == '0 || rd_delta != '0)
                    begin
                        state_next = ST_SYNC;
                    end
                end
                else if ((pend_reg || !can_pop) && !slot_open)
                begin
                    // hold until the output register frees up
                    state_next = ST_X_CHK;
                end
                else
                begin
                    if (pend_reg || !can_pop)
                    begin
                        rsp_valid_next         = 1'b1;
                        rsp_next.fired         = pend_reg;
                        rsp_next.fired_tag     = pend_reg ? pend_tag_reg : '0;
                        rsp_next.accepted      = 1'b0;
                        rsp_next.head_delay_us = head_view;
                        rsp_next.queue_empty   = (count_reg == '0);
                        rsp_next.last          = !can_pop;
                    end
                    if (can_pop)
                    begin
                        // pop the head and report it once the next head is read
                        pend_next     = 1'b1;
                        pend_tag_next = rd_tag;
                        count_next    = count_reg - CNT_BITS'(1);
                        free_next     = free_reg | (QUEUE_DEPTH'(1) << cur_reg);
                        head_next     = (count_reg == CNT_BITS'(1)) ? '0 : rd_link;
                        cur_next      = (count_reg == CNT_BITS'(1)) ? '0 : rd_link;
                        state_next    = ST_X_WAIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            free_reg      <= '1;
            count_reg     <= '0;
            sync_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            sync_reg      <= sync_next;
            rsp_valid_reg <= rsp_valid_next;
            first_reg     <= first_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        left_reg     <= left_next;
        elapsed_reg  <= elapsed_next;
        pend_tag_reg <= pend_tag_next;
        acc_reg      <= acc_next;
        item_reg     <= item_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// ===== rtl/dtq_free_pick.sv =====
// dtq_free_pick: picks the lowest free slot out of the free map.
// Depends on dtq_pkg.
module dtq_free_pick (
    input  logic [dtq_pkg::QUEUE_DEPTH-1:0] free_map,
    output logic [dtq_pkg::SLOT_BITS-1:0]   slot
);
    import dtq_pkg::*;

    always_comb
    begin
        slot = '0;
        // scan from the top so the lowest free slot wins
        for (int s = QUEUE_DEPTH - 1; s >= 0; s--)
        begin
            if (free_map[s])
            begin
                slot = SLOT_BITS'(s);
            end
        end
    end

endmodule
